@@ src/glyph_code_lookup_core_assert.svh @@
`ifndef GLYPH_CODE_LOOKUP_CORE_ASSERT_SVH
`define GLYPH_CODE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define GCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define GCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gcl_pkg.sv @@
package gcl_pkg;

  localparam int MAX_EXTRA_DEF = 1024;

  localparam int CHAR_W  = 32;
  localparam int CODE_W  = 21;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int IDX_W   = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int BASIC_LO = 32;
  localparam int BASIC_HI = 126;

  // Register indexes on the configuration port
  localparam int REG_FONT_PRESENT = 0;
  localparam int REG_EXTRA_COUNT  = 1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_BASIC   = 2'd1,
    KIND_EXTRA   = 2'd2,
    KIND_WRITE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic               font_present;
    logic [COUNT_W-1:0] extra_count;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

@@ src/gcl_if.sv @@
interface gcl_in_if;
  import gcl_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAR_W-1:0] char_code;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output operation, output char_code, output slot,
                  input ready);
  modport sink   (input valid, input operation, input char_code, input slot,
                  output ready);
endinterface

interface gcl_out_if;
  import gcl_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output kind, output entry_index, input ready);
  modport sink   (input valid, input kind, input entry_index, output ready);
endinterface

@@ src/gcl_cfg.sv @@
module gcl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcl_pkg::PADDR_W-1:0]  paddr,
  input  logic [gcl_pkg::PDATA_W-1:0]  pwdata,
  output logic [gcl_pkg::PDATA_W-1:0]  prdata,
  output gcl_pkg::cfg_t                cfg
);
  import gcl_pkg::*;

  logic               font_r,  font_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               wr_en;
  logic               reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    font_nxt  = font_r;
    count_nxt = count_r;
    if (wr_en) begin
      case (reg_sel)
        1'(REG_FONT_PRESENT): font_nxt  = pwdata[0];
        1'(REG_EXTRA_COUNT):  count_nxt = pwdata[COUNT_W-1:0];
        default:              font_nxt  = font_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_r  <= 1'b0;
      count_r <= '0;
    end else begin
      font_r  <= font_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      1'(REG_FONT_PRESENT): prdata = {{(PDATA_W-1){1'b0}}, font_r};
      1'(REG_EXTRA_COUNT):  prdata = {{(PDATA_W-COUNT_W){1'b0}}, count_r};
      default:              prdata = '0;
    endcase
  end

  assign cfg.font_present = font_r;
  assign cfg.extra_count  = count_r;

endmodule

@@ src/gcl_table.sv @@
module gcl_table #(
  parameter  int MAX_EXTRA = gcl_pkg::MAX_EXTRA_DEF,
  localparam int AW        = (MAX_EXTRA > 1) ? $clog2(MAX_EXTRA) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gcl_pkg::CODE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [gcl_pkg::CODE_W-1:0] rdata
);
  import gcl_pkg::*;

  logic [CODE_W-1:0] mem_r [MAX_EXTRA];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/gcl_seq.sv @@
module gcl_seq #(
  parameter  int MAX_EXTRA = gcl_pkg::MAX_EXTRA_DEF,
  localparam int AW        = (MAX_EXTRA > 1) ? $clog2(MAX_EXTRA) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gcl_in_if.sink                     in_ch,
  input  gcl_pkg::cfg_t              cfg,
  output logic                       tbl_we,
  output logic [AW-1:0]              tbl_waddr,
  output logic [gcl_pkg::CODE_W-1:0] tbl_wdata,
  output logic [AW-1:0]              tbl_raddr,
  input  logic [gcl_pkg::CODE_W-1:0] tbl_rdata,
  output gcl_pkg::res_t              res,
  input  logic                       res_take
);
  import gcl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_PROBE    = 5'b00010,
    S_PROBE_LO = 5'b00100,
    S_PROBE_HI = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  kind_t             kind_r, kind_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              accept;
  logic [31:0]       cnt32;
  logic [31:0]       hi0_full;
  logic [AW-1:0]     hi0;
  logic [AW-1:0]     mid0;
  logic [31:0]       slot32;
  logic              slot_ok;
  logic [CHAR_W-1:0] basic_off;

  // Shared compare unit and next-bound logic
  logic              eq;
  logic              lt;
  logic [AW-1:0]     nlo;
  logic [AW-1:0]     nhi;
  logic [AW:0]       nsum;
  logic [AW-1:0]     nmid;
  logic              adj;
  logic [AW-1:0]     hit_pos;
  logic [31:0]       hit32;

  assign accept = in_ch.valid & in_ch.ready;

  assign cnt32    = (32'(cfg.extra_count) > 32'(MAX_EXTRA)) ? 32'(MAX_EXTRA)
                                                             : 32'(cfg.extra_count);
  assign hi0_full = cnt32 - 32'd1;
  assign hi0      = hi0_full[AW-1:0];
  assign mid0     = hi0 >> 1;

  assign slot32    = 32'(in_ch.slot);
  assign slot_ok   = slot32 < 32'(MAX_EXTRA);
  assign basic_off = in_ch.char_code - CHAR_W'(BASIC_LO);

  assign eq   = tbl_rdata == code_r;
  assign lt   = code_r < tbl_rdata;
  assign nlo  = lt ? lo_r : mid_r;
  assign nhi  = lt ? mid_r : hi_r;
  assign nsum = {1'b0, nlo} + {1'b0, nhi};
  assign nmid = nsum[AW:1];
  assign adj  = ({1'b0, nlo} + (AW+1)'(1)) == {1'b0, nhi};

  assign tbl_waddr = slot32[AW-1:0];
  assign tbl_wdata = in_ch.char_code[CODE_W-1:0];

  always_comb begin
    case (state_r)
      S_PROBE_LO: hit_pos = lo_r;
      S_PROBE_HI: hit_pos = hi_r;
      default:    hit_pos = mid_r;
    endcase
  end
  assign hit32 = 32'(hit_pos);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    code_nxt  = code_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    tbl_we    = 1'b0;
    tbl_raddr = mid_r;

    case (state_r)
      S_IDLE: begin
        tbl_raddr = mid0;
        if (accept) begin
          state_nxt = S_DONE;
          idx_nxt   = '0;
          if (in_ch.operation == OP_WRITE) begin
            tbl_we   = slot_ok;
            kind_nxt = KIND_WRITE;
          end else if (!cfg.font_present || in_ch.char_code < CHAR_W'(BASIC_LO)) begin
            kind_nxt = KIND_INVALID;
          end else if (in_ch.char_code <= CHAR_W'(BASIC_HI)) begin
            kind_nxt = KIND_BASIC;
            idx_nxt  = basic_off[IDX_W-1:0];
          end else if (in_ch.char_code[CHAR_W-1:CODE_W] != '0 || cnt32 == 32'd0) begin
            kind_nxt = KIND_INVALID;
          end else begin
            // First probe address goes to the table this edge
            lo_nxt    = '0;
            hi_nxt    = hi0;
            mid_nxt   = mid0;
            code_nxt  = in_ch.char_code[CODE_W-1:0];
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (eq) begin
          kind_nxt  = KIND_EXTRA;
          idx_nxt   = hit32[IDX_W-1:0];
          state_nxt = S_DONE;
        end else if (lo_r == hi_r) begin
          kind_nxt  = KIND_INVALID;
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          lo_nxt  = nlo;
          hi_nxt  = nhi;
          mid_nxt = nmid;
          if (adj) begin
            tbl_raddr = nlo;
            state_nxt = S_PROBE_LO;
          end else begin
            tbl_raddr = nmid;
          end
        end
      end

      S_PROBE_LO: begin
        tbl_raddr = hi_r;
        if (eq) begin
          kind_nxt  = KIND_EXTRA;
          idx_nxt   = hit32[IDX_W-1:0];
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PROBE_HI;
        end
      end

      S_PROBE_HI: begin
        state_nxt = S_DONE;
        if (eq) begin
          kind_nxt = KIND_EXTRA;
          idx_nxt  = hit32[IDX_W-1:0];
        end else begin
          kind_nxt = KIND_INVALID;
          idx_nxt  = '0;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    code_r <= code_nxt;
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
  end

  assign in_ch.ready = state_r == S_IDLE;
  assign res.valid   = state_r == S_DONE;
  assign res.kind    = kind_r;
  assign res.index   = idx_r;

endmodule

@@ src/glyph_code_lookup_core.sv @@
// Glyph code lookup: each input beat either stores a 21-bit code into one slot
// of the extra-glyph table (kind "write done") or classifies a character code:
// invalid when no font is loaded or the code is below 32, a basic entry
// (index code-32) for 32..126, and otherwise a binary search over the first
// extra_count slots, which must hold ascending, unique codes written earlier.
// One item is in flight at a time: the input is not ready from a taken beat
// until its result has moved into the output register. Codes wider than 21
// bits, and lookups while extra_count is 0, are invalid without a search. A
// table search makes one probe per cycle on the single table read port. The
// result register lets the next item start while a result waits.
// The table has no reset; configuration (byte address 0: font_present,
// address 4: extra_count) should only change while the block is idle.
module glyph_code_lookup_core #(
  parameter int MAX_EXTRA = gcl_pkg::MAX_EXTRA_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gcl_in_if.sink                      in_ch,
  gcl_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcl_pkg::PADDR_W-1:0] paddr,
  input  logic [gcl_pkg::PDATA_W-1:0] pwdata,
  output logic [gcl_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import gcl_pkg::*;

  localparam int AW = (MAX_EXTRA > 1) ? $clog2(MAX_EXTRA) : 1;

  cfg_t              cfg;
  res_t              res;
  logic              res_take;

  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  logic [CODE_W-1:0] tbl_wdata;
  logic [AW-1:0]     tbl_raddr;
  logic [CODE_W-1:0] tbl_rdata;

  // Output register: holds one finished result until the sink takes the beat
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;

  // Writes land in the registers with no wait states
  assign pready = 1'b1;

  gcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Code table: one write port, one registered read port
  gcl_table #(.MAX_EXTRA(MAX_EXTRA)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Sequencer: classifies the item and walks the search, one probe a cycle
  gcl_seq #(.MAX_EXTRA(MAX_EXTRA)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .res       (res),
    .res_take  (res_take)
  );

  // Advance a finished result when the register is empty or being drained
  assign res_take = res.valid & (~out_valid_r | out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res.kind;
      out_idx_nxt   = res.index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.entry_index = out_idx_r;

endmodule

@@ src/gcl_checker.sv @@
`include "glyph_code_lookup_core_assert.svh"

module gcl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input gcl_pkg::kind_t            out_kind,
  input logic [gcl_pkg::IDX_W-1:0] out_index
);
  import gcl_pkg::*;

  // A pending result beat stays offered until taken
  `GCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // One item at a time: the input closes right after a beat is taken
  `GCL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken")

  // Invalid and write-done results carry a zero index
  `GCL_ASSERT_NOW(a_zero_idx, out_valid && (out_kind == KIND_INVALID || out_kind == KIND_WRITE),
                  out_index == '0, "nonzero index on invalid or write result")

  // Basic entries stay inside the printable range
  `GCL_ASSERT_NOW(a_basic_rng, out_valid && out_kind == KIND_BASIC,
                  out_index <= IDX_W'(BASIC_HI - BASIC_LO), "basic index out of range")

endmodule

bind glyph_code_lookup_core gcl_checker u_gcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_index (out_ch.entry_index)
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcl_pkg::*;

  // Cycles with no beat on either channel and no register access before giving up
  localparam int STALL_LIMIT     = 4000;
  // Minimum random lookups and writes per idling mode
  localparam int RANDOM_PER_MODE = 85;
  // Slots loaded with ascending codes; random traffic searches only these
  localparam int FILLED_SLOTS    = 256;
  // First probe of a search over the full table depth
  localparam int MID_SLOT        = (MAX_EXTRA_DEF - 1) / 2;
  localparam logic [CODE_W-1:0] TOP_CODE = '1;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
  } glyph_res_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gcl_in_if  in_if ();
  gcl_out_if out_if ();

  glyph_code_lookup_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the glyph table and of the two registers
  logic [CODE_W-1:0]  glyph_table [MAX_EXTRA_DEF];
  logic               font_shadow  = 1'b0;
  logic [COUNT_W-1:0] count_shadow = '0;

  glyph_res_t pending_results [$];
  glyph_res_t head;

  int src_idle_pct  = 12;
  int snk_stall_pct = 63;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int seen_basic    = 0;
  int seen_extra    = 0;
  int seen_invalid  = 0;
  int seen_write    = 0;

  // Work out the result of one beat; a write also updates the shadow table.
  // The search narrows with a midpoint and probes both ends once they touch.
  function automatic glyph_res_t predict_glyph(op_t op, logic [CHAR_W-1:0] code,
                                               logic [SLOT_W-1:0] slot);
    glyph_res_t        res;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    int unsigned       n;
    logic [CODE_W-1:0] key;
    bit                done;
    res.kind = KIND_INVALID;
    res.idx  = '0;
    key      = code[CODE_W-1:0];
    // Clamp an oversized count to the table depth
    n = (count_shadow > MAX_EXTRA_DEF) ? MAX_EXTRA_DEF : count_shadow;
    if (op == OP_WRITE) begin
      glyph_table[slot] = key;
      res.kind = KIND_WRITE;
    end else if (font_shadow && code >= BASIC_LO) begin
      if (code <= BASIC_HI) begin
        res.kind = KIND_BASIC;
        res.idx  = IDX_W'(code - BASIC_LO);
      end else if (code[CHAR_W-1:CODE_W] == '0 && n != 0) begin
        lo   = 0;
        hi   = n - 1;
        done = 1'b0;
        while (!done) begin
          mid = (lo + hi) >> 1;
          if (glyph_table[mid] == key) begin
            res.kind = KIND_EXTRA;
            res.idx  = IDX_W'(mid);
            done     = 1'b1;
          end else if (lo == hi) begin
            done = 1'b1;
          end else begin
            if (key < glyph_table[mid]) hi = mid;
            else lo = mid;
            if (lo + 1 == hi) begin
              done = 1'b1;
              if (glyph_table[lo] == key) begin
                res.kind = KIND_EXTRA;
                res.idx  = IDX_W'(lo);
              end else if (glyph_table[hi] == key) begin
                res.kind = KIND_EXTRA;
                res.idx  = IDX_W'(hi);
              end
            end
          end
        end
      end
    end
    return res;
  endfunction

  // Offer one beat, idling first at random; valid stays high afterwards so a
  // back-to-back beat needs no second assignment in the same step.
  task automatic send_glyph_item(op_t op, logic [CHAR_W-1:0] code, logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.char_code <= code;
    in_if.slot      <= slot;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_glyph(op, code, slot));
  endtask

  task automatic lookup_code(logic [CHAR_W-1:0] code);
    send_glyph_item(OP_LOOKUP, code, SLOT_W'($urandom_range(MAX_EXTRA_DEF - 1)));
  endtask

  // Store a code, with random junk above bit 20 that the block must drop
  task automatic write_slot(int slot, logic [CODE_W-1:0] value);
    logic [CHAR_W-1:0] code;
    code = $urandom;
    code[CODE_W-1:0] = value;
    send_glyph_item(OP_WRITE, code, SLOT_W'(slot));
  endtask

  // Drop valid, hold until every result is back, then let the block settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, logic [PDATA_W-1:0] data);
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= data;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FONT_PRESENT: font_shadow  = data[0];
      REG_EXTRA_COUNT:  count_shadow = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(int idx, logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    paddr   <= PADDR_W'(idx * 4);
    pwrite  <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      $display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, got);
      mismatches++;
    end
  endtask

  // Reset values, then write and read back both registers
  task automatic test_register_file();
    check_reg(REG_FONT_PRESENT, 0);
    check_reg(REG_EXTRA_COUNT, 0);
    cfg_write(REG_FONT_PRESENT, 1);
    cfg_write(REG_EXTRA_COUNT, MAX_EXTRA_DEF);
    check_reg(REG_FONT_PRESENT, 1);
    check_reg(REG_EXTRA_COUNT, MAX_EXTRA_DEF);
    cfg_write(REG_FONT_PRESENT, 0);
    cfg_write(REG_EXTRA_COUNT, 0);
  endtask

  // With no font every lookup is invalid, while writes still land. Fill the
  // low slots with ascending codes and park the top code in the first probe
  // slot of a full-depth search: a full-depth search for a code up to the last
  // filled one then only walks written slots.
  task automatic test_load_without_font();
    logic [CODE_W-1:0] code;
    lookup_code(65);
    lookup_code(300);
    lookup_code(0);
    code = CODE_W'($urandom_range(1500, 128));
    for (int s = 0; s < FILLED_SLOTS; s++) begin
      write_slot(s, code);
      code = code + CODE_W'($urandom_range(2000, 1));
    end
    write_slot(MID_SLOT, TOP_CODE);
    lookup_code({11'b0, glyph_table[3]});
    drain_results();
  endtask

  task automatic test_directed_codes();
    cfg_write(REG_FONT_PRESENT, 1);
    // Empty table: nothing outside the basic range matches
    lookup_code(200);
    lookup_code({11'b0, TOP_CODE});
    drain_results();
    // Full depth: keep codes at or below the last filled slot, or the top code
    cfg_write(REG_EXTRA_COUNT, MAX_EXTRA_DEF);
    lookup_code(0);
    lookup_code(31);
    lookup_code(32);
    lookup_code(126);
    lookup_code(127);
    lookup_code({11'b0, glyph_table[0]});
    lookup_code({11'b0, glyph_table[FILLED_SLOTS / 2]});
    lookup_code({11'b0, glyph_table[FILLED_SLOTS - 1]});
    lookup_code({11'b0, TOP_CODE});
    lookup_code({11'b0, glyph_table[5]} + 1);
    // Codes above 21 bits never match, even when the low bits would
    lookup_code(32'h0020_0000);
    lookup_code(32'hFFFF_FFFF);
    lookup_code(32'h8000_0041);
    lookup_code({11'h400, glyph_table[7]});
    drain_results();
    // Tiny tables reach the single-entry and adjacent-ends paths
    for (int c = 1; c <= 3; c++) begin
      cfg_write(REG_EXTRA_COUNT, c);
      lookup_code({11'b0, glyph_table[c - 1]});
      lookup_code({11'b0, glyph_table[0]});
      lookup_code({11'b0, glyph_table[c]});
      drain_results();
    end
    // Count beyond the table depth clamps to the full table
    cfg_write(REG_EXTRA_COUNT, 2047);
    lookup_code({11'b0, glyph_table[FILLED_SLOTS - 1]});
    drain_results();
    cfg_write(REG_EXTRA_COUNT, MAX_EXTRA_DEF + 1);
    lookup_code({11'b0, glyph_table[100]});
    drain_results();
  endtask

  // Scramble the head of the table (duplicates included), search it, restore it
  task automatic test_unsorted_table();
    logic [CODE_W-1:0] saved [16];
    logic [CODE_W-1:0] pool  [4];
    for (int i = 0; i < 4; i++) pool[i] = CODE_W'($urandom_range(32'h1F_FFFF, 127));
    for (int i = 0; i < 16; i++) begin
      saved[i] = glyph_table[i];
      if ($urandom_range(1)) write_slot(i, pool[$urandom_range(3)]);
      else write_slot(i, CODE_W'($urandom));
    end
    drain_results();
    cfg_write(REG_FONT_PRESENT, 1);
    cfg_write(REG_EXTRA_COUNT, $urandom_range(16, 1));
    repeat (24) begin
      if ($urandom_range(2) != 0) lookup_code({11'b0, glyph_table[$urandom_range(15)]});
      else lookup_code($urandom_range(32'h1F_FFFF, 127));
    end
    drain_results();
    for (int i = 0; i < 16; i++) write_slot(i, saved[i]);
    drain_results();
  endtask

  // One random beat, biased toward codes the table holds and their neighbors
  task automatic random_item(int n);
    int          r;
    int          s;
    int unsigned lo_b;
    int unsigned hi_b;
    r = $urandom_range(99);
    if (r < 40 && n > 0) begin
      lookup_code({11'b0, glyph_table[$urandom_range(n - 1)]});
    end else if (r < 58 && n > 0) begin
      s = $urandom_range(n - 1);
      if ($urandom_range(1)) lookup_code({11'b0, glyph_table[s]} + 1);
      else lookup_code({11'b0, glyph_table[s]} - 1);
    end else if (r < 68) begin
      lookup_code($urandom_range(BASIC_HI, BASIC_LO));
    end else if (r < 73) begin
      lookup_code($urandom_range(BASIC_LO - 1, 0));
    end else if (r < 80) begin
      lookup_code($urandom | (32'h1 << $urandom_range(CHAR_W - 1, CODE_W)));
    end else if (r < 88) begin
      lookup_code($urandom_range(32'h1F_FFFF, 127));
    end else begin
      // Rewrite a filled slot with a code that keeps the table ascending
      s    = $urandom_range(FILLED_SLOTS - 1);
      lo_b = (s == 0) ? 127 : glyph_table[s - 1] + 1;
      hi_b = (s == FILLED_SLOTS - 1) ? TOP_CODE - 1 : glyph_table[s + 1] - 1;
      write_slot(s, CODE_W'($urandom_range(hi_b, lo_b)));
    end
  endtask

  // Counts stay within the filled slots; full depth is covered above
  task automatic test_random_traffic();
    int                 sent;
    int                 r;
    int                 n;
    logic [COUNT_W-1:0] cnt;
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 12 : (mode == 1) ? 63 : 0;
      snk_stall_pct = (mode == 0) ? 63 : (mode == 1) ? 12 : 0;
      sent = 0;
      while (sent < RANDOM_PER_MODE) begin
        drain_results();
        r = $urandom_range(99);
        if (r < 30)      cnt = COUNT_W'(FILLED_SLOTS);
        else if (r < 45) cnt = $urandom_range(3, 1);
        else if (r < 50) cnt = 0;
        else             cnt = COUNT_W'($urandom_range(FILLED_SLOTS, 1));
        cfg_write(REG_FONT_PRESENT, ($urandom_range(9) != 0));
        cfg_write(REG_EXTRA_COUNT, cnt);
        n = (cnt > MAX_EXTRA_DEF) ? MAX_EXTRA_DEF : cnt;
        repeat ($urandom_range(50, 20)) begin
          // Hold off now and then until the block has answered everything
          if ($urandom_range(39) == 0) drain_results();
          random_item(n);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  // Receiver: stall at random with the current percentage
  always @(posedge clk) out_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  // Compare every result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      case (out_if.kind)
        KIND_BASIC: seen_basic++;
        KIND_EXTRA: seen_extra++;
        KIND_WRITE: seen_write++;
        default:    seen_invalid++;
      endcase
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d index %0d",
                 $time, out_if.kind, out_if.entry_index);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (out_if.kind !== head.kind) begin
          $display("%0t: kind mismatch, expected %0d actual %0d",
                   $time, head.kind, out_if.kind);
          mismatches++;
        end
        if (out_if.entry_index !== head.idx) begin
          $display("%0t: entry_index mismatch, expected %0d actual %0d",
                   $time, head.idx, out_if.entry_index);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any beat or register access counts as progress
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[glyph_code_lookup_core] ERROR");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = 1'b0;
    in_if.char_code = '0;
    in_if.slot      = '0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_file();
    test_load_without_font();
    test_directed_codes();
    test_unsorted_table();
    test_random_traffic();

    // Let any stray beat show up before judging
    repeat (20) @(posedge clk);
    $display("Covered %0d basic hits, %0d table hits and %0d invalid lookups,",
             seen_basic, seen_extra, seen_invalid);
    $display("plus %0d table writes, over three idling modes and several table sizes.",
             seen_write);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[glyph_code_lookup_core] OK");
    end else begin
      $display("[glyph_code_lookup_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/gcl_pkg.sv
src/gcl_if.sv
src/gcl_cfg.sv
src/gcl_table.sv
src/gcl_seq.sv
src/glyph_code_lookup_core.sv
src/gcl_checker.sv
tb/testbench.sv
